@@ sv/ipv4_route_table_lpm_unit_assert.svh @@
// Assertion macros for the IPv4 route table unit.
// Used by the top level; needs no other file.
`ifndef IPV4_ROUTE_TABLE_LPM_UNIT_ASSERT_SVH
`define IPV4_ROUTE_TABLE_LPM_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define RTLPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("route table assertion failed");

// Next-cycle implication, disabled while reset is active.
`define RTLPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("route table assertion failed");

`endif

@@ sv/rtlpm_pkg.sv @@
// Shared types and codes of the IPv4 route table unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtlpm_pkg;

	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_STATIC = 2'd1;
	localparam logic [1:0] MODE_UPSERT = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_BADLEN  = 2'd2;
	localparam logic [1:0] STAT_NOROUTE = 2'd3;

	localparam logic [5:0] MAX_LEN   = 6'd32;
	localparam int         HIT_IDX_W = 4;

	typedef struct packed {
		logic [31:0] prefix;
		logic [5:0]  len;
		logic [31:0] gateway;
		logic [3:0]  iface;
		logic        is_static;
		logic        active;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic scan_step;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_scan;
		logic scan_last;
	} sts_t;

	// Network mask for a prefix length; zero length gives no bits, 32 and up all bits.
	function automatic logic [31:0] len_mask(input logic [5:0] len);
		return ~(32'hFFFF_FFFF >> len);
	endfunction

endpackage

`default_nettype wire

@@ sv/ipv4_route_table_lpm_unit.sv @@
// Top level of the IPv4 route table with longest-prefix-match lookup.
// Depends on rtlpm_pkg, rtlpm_ctrl, rtlpm_dp and the assertion macro header.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | input     | in_valid / in_ready   | mode dest_addr route_prefix route_len
//           |           |                      | gateway iface_id enabled
//   out     | output    | out_valid / out_ready | status found hit_index hit_gateway
//           |           |                      | hit_iface hit_len hit_static
//
// An item that scans the table (lookup or upsert with n stored routes, n from 1 to MAX_ROUTES)
// passes a check step, the scan, a drain step for the last registered read and a finishing
// step that writes back and loads the result; other items go from the check step straight
// to the finishing step. The route store RAM is read one entry per cycle during the scan.
// Reset clears the route count and the control state; the route store is not cleared.
// A stalled output holds the result register; the next item is taken meanwhile and waits
// in its finishing step until the register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "ipv4_route_table_lpm_unit_assert.svh"

module ipv4_route_table_lpm_unit #(
	parameter int MAX_ROUTES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] dest_addr,
	input  wire logic [31:0] route_prefix,
	input  wire logic [5:0]  route_len,
	input  wire logic [31:0] gateway,
	input  wire logic [3:0]  iface_id,
	input  wire logic        enabled,
	// output channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic             found,
	output logic [3:0]       hit_index,
	output logic [31:0]      hit_gateway,
	output logic [3:0]       hit_iface,
	output logic [5:0]       hit_len,
	output logic             hit_static
);

	import rtlpm_pkg::*;

	// route index and route count widths follow the table depth
	localparam int IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
	localparam int CNT_W = $clog2(MAX_ROUTES + 1);

	cmd_t cmd;
	sts_t sts;
	logic in_xfer;

	assign in_xfer = in_valid && in_ready;

	// controller: owns the handshakes and steps the datapath through each item
	rtlpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath: item registers, route store, best-match tracking, result register
	rtlpm_dp #(
		.MAX_ROUTES (MAX_ROUTES),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (mode),
		.dest_addr    (dest_addr),
		.route_prefix (route_prefix),
		.route_len    (route_len),
		.gateway      (gateway),
		.iface_id     (iface_id),
		.enabled      (enabled),
		.status       (status),
		.found        (found),
		.hit_index    (hit_index),
		.hit_gateway  (hit_gateway),
		.hit_iface    (hit_iface),
		.hit_len      (hit_len),
		.hit_static   (hit_static)
	);

	// the block is busy right after a transfer in
	`RTLPM_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_xfer, !in_ready)
	// a result is loaded only into a free output register
	`RTLPM_ASSERT_NOW(a_finish_free, clk, arst_n, cmd.finish, !out_valid || out_ready)
	// a loaded result is offered in the next cycle
	`RTLPM_ASSERT_NEXT(a_finish_valid, clk, arst_n, cmd.finish, out_valid)
	// a found route always reports success
	`RTLPM_ASSERT_NOW(a_found_ok, clk, arst_n, out_valid && found, status == STAT_OK)

endmodule

`default_nettype wire

@@ sv/rtlpm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rtlpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/rtlpm_dp.sv @@
// Datapath of the IPv4 route table: item registers, route store, scan compare, result.
// Depends on rtlpm_pkg and rtlpm_ram.
`timescale 1ns / 1ps
`default_nettype none

module rtlpm_dp #(
	parameter int MAX_ROUTES = 16,
	parameter int IDX_W      = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1,
	parameter int CNT_W      = $clog2(MAX_ROUTES + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rtlpm_pkg::cmd_t cmd,
	output rtlpm_pkg::sts_t    sts,
	input  wire logic [1:0]    mode,
	input  wire logic [31:0]   dest_addr,
	input  wire logic [31:0]   route_prefix,
	input  wire logic [5:0]    route_len,
	input  wire logic [31:0]   gateway,
	input  wire logic [3:0]    iface_id,
	input  wire logic          enabled,
	output logic [1:0]         status,
	output logic               found,
	output logic [3:0]         hit_index,
	output logic [31:0]        hit_gateway,
	output logic [3:0]         hit_iface,
	output logic [5:0]         hit_len,
	output logic               hit_static
);

	import rtlpm_pkg::*;

	localparam int HW = (IDX_W > HIT_IDX_W) ? IDX_W : HIT_IDX_W;

	// item registers
	logic [1:0]  mode_q;
	logic [31:0] dest_q, prefix_q, gw_q;
	logic [5:0]  len_q;
	logic [3:0]  ifc_q;
	logic        act_q;

	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             have_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [5:0]       best_len_q;
	logic             best_static_q;
	logic [31:0]      best_gw_q;
	logic [3:0]       best_iface_q;
	logic             upd_hit_q;
	logic [IDX_W-1:0] upd_idx_q;

	logic [$bits(entry_t)-1:0] rd_data;
	entry_t e;
	entry_t wr_entry;
	logic   wr_en;
	logic   append;
	logic [IDX_W-1:0] wr_idx;
	logic   qualify, better, upd_match;
	logic   len_bad, full;

	logic [1:0]       res_status;
	logic             res_found;
	logic [IDX_W-1:0] res_idx;
	logic [31:0]      res_gw;
	logic [3:0]       res_iface;
	logic [5:0]       res_len;
	logic             res_static;
	logic [HW-1:0]    res_idx_w;

	assign e       = entry_t'(rd_data);
	assign len_bad = len_q > MAX_LEN;
	assign full    = count_q == CNT_W'(MAX_ROUTES);

	assign sts.need_scan = (mode_q == MODE_LOOKUP || mode_q == MODE_UPSERT) &&
		(count_q != '0);
	assign sts.scan_last = CNT_W'(scan_idx_q) == (count_q - CNT_W'(1));

	rtlpm_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_ROUTES),
		.AW    (IDX_W)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (wr_entry),
		.re    (cmd.scan_step),
		.raddr (scan_idx_q),
		.rdata (rd_data)
	);

	// compare of the entry read in the previous cycle
	always_comb begin
		qualify   = e.active && (((dest_q ^ e.prefix) & len_mask(e.len)) == 32'd0);
		better    = !have_q || (e.len > best_len_q) ||
			((e.len == best_len_q) && e.is_static && !best_static_q);
		upd_match = !e.is_static && (e.iface == ifc_q) && !upd_hit_q;
	end

	// result and store write for the finishing item
	always_comb begin
		res_status = STAT_OK;
		res_found  = 1'b0;
		res_idx    = '0;
		res_gw     = '0;
		res_iface  = '0;
		res_len    = '0;
		res_static = 1'b0;
		wr_en      = 1'b0;
		append     = 1'b0;
		wr_idx     = count_q[IDX_W-1:0];
		case (mode_q) inside
			MODE_LOOKUP: begin
				if (have_q) begin
					res_found  = 1'b1;
					res_idx    = best_idx_q;
					res_gw     = best_gw_q;
					res_iface  = best_iface_q;
					res_len    = best_len_q;
					res_static = best_static_q;
				end else begin
					res_status = STAT_NOROUTE;
				end
			end
			MODE_STATIC, MODE_UPSERT: begin
				if (len_bad) begin
					res_status = STAT_BADLEN;
				end else if (mode_q == MODE_UPSERT && upd_hit_q) begin
					wr_en   = cmd.finish;
					wr_idx  = upd_idx_q;
					res_idx = upd_idx_q;
				end else if (full) begin
					res_status = STAT_FULL;
				end else begin
					wr_en   = cmd.finish;
					append  = 1'b1;
					res_idx = count_q[IDX_W-1:0];
				end
			end
			default: begin
				res_status = STAT_OK;
			end
		endcase
		res_idx_w = HW'(res_idx);
	end

	always_comb begin
		wr_entry.prefix    = prefix_q;
		wr_entry.len       = len_q;
		wr_entry.gateway   = (mode_q == MODE_STATIC) ? gw_q : 32'd0;
		wr_entry.iface     = ifc_q;
		wr_entry.is_static = mode_q == MODE_STATIC;
		wr_entry.active    = act_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
			have_q     <= 1'b0;
			upd_hit_q  <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan_step;
			if (cmd.load_in) begin
				scan_idx_q <= '0;
				have_q     <= 1'b0;
				upd_hit_q  <= 1'b0;
			end else begin
				if (cmd.scan_step) begin
					scan_idx_q <= scan_idx_q + IDX_W'(1);
				end
				if (cmp_vld_s1 && mode_q == MODE_LOOKUP && qualify && better) begin
					have_q <= 1'b1;
				end
				if (cmp_vld_s1 && mode_q == MODE_UPSERT && upd_match) begin
					upd_hit_q <= 1'b1;
				end
			end
			if (cmd.finish && append) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q   <= mode;
			dest_q   <= dest_addr;
			prefix_q <= route_prefix;
			len_q    <= route_len;
			gw_q     <= gateway;
			ifc_q    <= iface_id;
			act_q    <= enabled;
		end
		if (cmd.scan_step) begin
			idx_s1 <= scan_idx_q;
		end
		if (cmp_vld_s1 && mode_q == MODE_LOOKUP && qualify && better) begin
			best_idx_q    <= idx_s1;
			best_len_q    <= e.len;
			best_static_q <= e.is_static;
			best_gw_q     <= e.gateway;
			best_iface_q  <= e.iface;
		end
		if (cmp_vld_s1 && mode_q == MODE_UPSERT && upd_match) begin
			upd_idx_q <= idx_s1;
		end
		if (cmd.finish) begin
			status      <= res_status;
			found       <= res_found;
			hit_index   <= res_idx_w[HIT_IDX_W-1:0];
			hit_gateway <= res_gw;
			hit_iface   <= res_iface;
			hit_len     <= res_len;
			hit_static  <= res_static;
		end
	end

endmodule

`default_nettype wire

@@ sv/rtlpm_ctrl.sv @@
// Controller of the IPv4 route table: sequences accept, scan, finish and output handshake.
// Depends on rtlpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtlpm_ctrl (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output rtlpm_pkg::cmd_t cmd,
	input  wire rtlpm_pkg::sts_t sts
);

	import rtlpm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_free;

	assign in_ready = state_q == S_IDLE;
	assign out_free = !out_valid || out_ready;

	always_comb begin
		cmd.load_in   = (state_q == S_IDLE) && in_valid;
		cmd.scan_step = state_q == S_SCAN;
		cmd.finish    = (state_q == S_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			// raise on a loaded result, drop once the result is transferred
			out_valid <= cmd.finish || (out_valid && !out_ready);
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= sts.need_scan ? S_SCAN : S_FINISH;
				end
				S_SCAN: begin
					if (sts.scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					// hold the result until the output register is free
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
